@@ src/acm_pkg.sv @@
// Package with shared constants, types and helper functions for the arc coverage merge block.
`timescale 1ns / 1ps

package acm_pkg;

  localparam int MAX_ARCS  = 16;
  localparam int TURN_BITS = 16;

  localparam int ANG_W     = TURN_BITS + 1;
  localparam int IDX_W     = $clog2(MAX_ARCS);
  localparam int CNT_W     = $clog2(MAX_ARCS + 1);
  localparam int ACC_W     = ANG_W + 1;

  localparam int FIELD_W   = 17;
  localparam int LEN_OUT_W = 17;
  localparam int CNT_OUT_W = 5;

  localparam int S_TDATA_W = ((2 * FIELD_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((LEN_OUT_W + CNT_OUT_W + 7) / 8) * 8;

  localparam int CLAMP_W   = (FIELD_W > ANG_W) ? FIELD_W : ANG_W;
  localparam int LSAT_W    = (ACC_W > LEN_OUT_W) ? ACC_W : LEN_OUT_W;
  localparam int CSAT_W    = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

  localparam logic [ANG_W-1:0] ONE_TURN = {1'b1, {TURN_BITS{1'b0}}};

  typedef struct packed {
    logic             clr;
    logic             kill;
    logic             wr;
    logic [IDX_W-1:0] wr_idx;
    logic [ANG_W-1:0] wr_start;
    logic [ANG_W-1:0] wr_end;
  } store_cmd_t;

  // Angles above one full turn saturate to one turn.
  function automatic logic [ANG_W-1:0] clamp_angle(input logic [FIELD_W-1:0] v);
    logic [CLAMP_W-1:0] w;
    logic [CLAMP_W-1:0] one;
    begin
      w   = CLAMP_W'(v);
      one = CLAMP_W'(ONE_TURN);
      if (w > one) begin
        return ONE_TURN;
      end
      return ANG_W'(w);
    end
  endfunction

  function automatic logic [LEN_OUT_W-1:0] sat_len(input logic [ACC_W-1:0] a);
    logic [LSAT_W-1:0] w;
    logic [LSAT_W-1:0] lim;
    begin
      w   = LSAT_W'(a);
      lim = LSAT_W'({LEN_OUT_W{1'b1}});
      if (w > lim) begin
        return {LEN_OUT_W{1'b1}};
      end
      return LEN_OUT_W'(w);
    end
  endfunction

  function automatic logic [CNT_OUT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    logic [CSAT_W-1:0] w;
    logic [CSAT_W-1:0] lim;
    begin
      w   = CSAT_W'(c);
      lim = CSAT_W'({CNT_OUT_W{1'b1}});
      if (w > lim) begin
        return {CNT_OUT_W{1'b1}};
      end
      return CNT_OUT_W'(w);
    end
  endfunction

endpackage

@@ src/acm_slot_store.sv @@
// Arc slot storage: per-slot valid bits, start and end registers, and the held-arc count.
`timescale 1ns / 1ps

module acm_slot_store (
  input  logic                          clk,
  input  logic                          rst,
  input  acm_pkg::store_cmd_t           cmd,
  input  logic [acm_pkg::IDX_W-1:0]     rd_idx,
  output logic                          rd_valid,
  output logic [acm_pkg::ANG_W-1:0]     rd_start,
  output logic [acm_pkg::ANG_W-1:0]     rd_end,
  output logic [acm_pkg::CNT_W-1:0]     count
);
  import acm_pkg::*;

  logic [MAX_ARCS-1:0] valid;
  logic [ANG_W-1:0]    slot_start [MAX_ARCS];
  logic [ANG_W-1:0]    slot_end   [MAX_ARCS];

  assign rd_valid = valid[rd_idx];
  assign rd_start = slot_start[rd_idx];
  assign rd_end   = slot_end[rd_idx];

  // The sequencer never kills and writes in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (cmd.clr) begin
      valid <= '0;
      count <= '0;
    end else if (cmd.kill) begin
      valid[rd_idx] <= 1'b0;
      count         <= count - CNT_W'(1);
    end else if (cmd.wr) begin
      valid[cmd.wr_idx] <= 1'b1;
      count             <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      slot_start[cmd.wr_idx] <= cmd.wr_start;
      slot_end[cmd.wr_idx]   <= cmd.wr_end;
    end
  end

endmodule

@@ src/acm_merge_unit.sv @@
// Shared merge unit: tests one stored arc against the growing piece and absorbs it on overlap.
`timescale 1ns / 1ps

module acm_merge_unit (
  input  logic                      clk,
  input  logic                      load,
  input  logic [acm_pkg::ANG_W-1:0] load_start,
  input  logic [acm_pkg::ANG_W-1:0] load_end,
  input  logic                      step_en,
  input  logic                      slot_valid,
  input  logic [acm_pkg::ANG_W-1:0] slot_start,
  input  logic [acm_pkg::ANG_W-1:0] slot_end,
  output logic                      hit,
  output logic [acm_pkg::ANG_W-1:0] ms,
  output logic [acm_pkg::ANG_W-1:0] me,
  output logic [acm_pkg::ANG_W-1:0] gain
);
  import acm_pkg::*;

  logic [ANG_W-1:0] absorbed;

  // Touching arcs count as overlapping.
  assign hit  = slot_valid && !((slot_end < ms) || (slot_start > me));
  assign gain = (me - ms) - absorbed;

  always_ff @(posedge clk) begin
    if (load) begin
      ms       <= load_start;
      me       <= load_end;
      absorbed <= '0;
    end else if (step_en && hit) begin
      absorbed <= absorbed + (slot_end - slot_start);
      if (slot_start < ms) begin
        ms <= slot_start;
      end
      if (slot_end > me) begin
        me <= slot_end;
      end
    end
  end

endmodule

@@ src/arc_coverage_merge.sv @@
// Top level of the arc coverage merge block: stream ports, sequencer and output register.
`timescale 1ns / 1ps

// The block holds up to MAX_ARCS disjoint arcs on a circle and, for each offered arc,
// returns the newly covered length, an overflow flag and the number of arcs held. One
// transaction is taken at a time: s_tready is high only while the sequencer is idle. Each
// piece of an arc (a wrapping arc is two pieces) is merged by walking all slots one per
// cycle through a single compare-and-merge unit; the walk repeats while it absorbed
// anything, and the piece is then placed in a free slot. The result sits in an output
// register, so the next transaction is accepted while it waits to be taken.
module arc_coverage_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata fields from bit 0: arc_start[16:0], arc_end[33:17], zero fill.
  input  logic [acm_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser fields from bit 0: clear_first.
  input  logic [0:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata fields from bit 0: added_length[16:0], arc_count[21:17], zero fill.
  output logic [acm_pkg::M_TDATA_W-1:0] m_tdata,
  // m_tuser fields from bit 0: store_overflow.
  output logic [0:0]                    m_tuser
);
  import acm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_PLACE, S_FINISH} state_t;

  state_t           state;
  logic [IDX_W-1:0] idx;
  logic             changed;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             second_pend;
  logic [ANG_W-1:0] e2;
  logic [ACC_W-1:0] added;
  logic             ovf;

  logic             accept;
  logic [ANG_W-1:0] in_s;
  logic [ANG_W-1:0] in_e;
  logic             wrap;
  logic             last;
  logic             changed_now;

  store_cmd_t       cmd;
  logic             rd_valid;
  logic [ANG_W-1:0] rd_start;
  logic [ANG_W-1:0] rd_end;
  logic [CNT_W-1:0] count;

  logic             load;
  logic [ANG_W-1:0] load_start;
  logic [ANG_W-1:0] load_end;
  logic             hit;
  logic [ANG_W-1:0] ms;
  logic [ANG_W-1:0] me;
  logic [ANG_W-1:0] gain;

  assign s_tready    = (state == S_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign in_s        = clamp_angle(s_tdata[FIELD_W-1:0]);
  assign in_e        = clamp_angle(s_tdata[2*FIELD_W-1:FIELD_W]);
  assign wrap        = in_s > in_e;
  assign last        = (idx == IDX_W'(MAX_ARCS - 1));
  assign changed_now = changed || hit;

  assign load       = accept || ((state == S_PLACE) && second_pend);
  assign load_start = accept ? in_s : '0;
  assign load_end   = accept ? (wrap ? ONE_TURN : in_e) : e2;

  always_comb begin
    cmd          = '0;
    cmd.clr      = accept && s_tuser[0];
    cmd.kill     = (state == S_WALK) && hit;
    cmd.wr       = (state == S_PLACE) && free_found;
    cmd.wr_idx   = free_idx;
    cmd.wr_start = ms;
    cmd.wr_end   = me;
  end

  acm_slot_store u_store (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rd_idx   (idx),
    .rd_valid (rd_valid),
    .rd_start (rd_start),
    .rd_end   (rd_end),
    .count    (count)
  );

  acm_merge_unit u_merge (
    .clk        (clk),
    .load       (load),
    .load_start (load_start),
    .load_end   (load_end),
    .step_en    (state == S_WALK),
    .slot_valid (rd_valid),
    .slot_start (rd_start),
    .slot_end   (rd_end),
    .hit        (hit),
    .ms         (ms),
    .me         (me),
    .gain       (gain)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      changed     <= 1'b0;
      free_found  <= 1'b0;
      second_pend <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // In S_FINISH a new result may refill the register as the old one leaves.
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            added       <= '0;
            ovf         <= 1'b0;
            second_pend <= wrap;
            e2          <= in_e;
            idx         <= '0;
            changed     <= 1'b0;
            free_found  <= 1'b0;
            state       <= S_WALK;
          end
        end
        S_WALK: begin
          // A slot freed by this walk counts as free; only the final walk,
          // which absorbs nothing, leaves its record standing.
          if (!free_found && (!rd_valid || hit) && !(last && changed_now)) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (last) begin
            idx <= '0;
            if (changed_now) begin
              changed    <= 1'b0;
              free_found <= 1'b0;
            end else begin
              state <= S_PLACE;
            end
          end else begin
            idx     <= idx + IDX_W'(1);
            changed <= changed_now;
          end
        end
        S_PLACE: begin
          if (free_found) begin
            added <= added + ACC_W'(gain);
          end else begin
            ovf <= 1'b1;
          end
          if (second_pend) begin
            second_pend <= 1'b0;
            idx         <= '0;
            changed     <= 1'b0;
            free_found  <= 1'b0;
            state       <= S_WALK;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= M_TDATA_W'({sat_count(count), sat_len(added)});
            m_tuser  <= ovf;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/acm_checker.sv @@
// Port-level checker for the arc coverage merge block and its bind to the top level.
`timescale 1ns / 1ps

module acm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [acm_pkg::S_TDATA_W-1:0] s_tdata,
  input logic [0:0]                    s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [acm_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [0:0]                    m_tuser
);
  import acm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted again before the merge walk ran");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (int'(m_tdata[LEN_OUT_W+CNT_OUT_W-1:LEN_OUT_W]) <= MAX_ARCS))
    else $error("arc count above store depth");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind arc_coverage_merge acm_checker u_acm_checker (.*);
